>>> hdl/cfl_pkg.sv
// Shared types and constants for the CFL timestep reduction block.
// No dependencies; every other file but cfl_checker refers to it by scoped names.
`default_nettype none

package cfl_pkg;

    // Value formats: Q16.16 quantities, Q0.16 coefficients.
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned COEF_W = 16;

    // Serial arithmetic unit step counts (one quotient or root bit, or one
    // multiplier bit, per cycle).
    localparam int unsigned DIV_STEPS  = VAL_W;
    localparam int unsigned SQRT_STEPS = (VAL_W + FRAC_W) / 2;
    localparam int unsigned MUL_STEPS  = COEF_W;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int unsigned SHF_W      = VAL_W + FRAC_W;

    localparam logic [VAL_W-1:0] QMAX = '1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUND_COEFF,
        CFG_FORCE_COEFF,
        CFG_FIXED_STEP
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] sound_coeff;
        logic [COEF_W-1:0] force_coeff;
        logic [VAL_W-1:0]  fixed_step;
    } cfg_t;

    // Operations of the serial arithmetic unit.
    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQRT,
        OP_MUL
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    // One result item.
    typedef struct packed {
        logic [VAL_W-1:0] time_step;
        logic [VAL_W-1:0] min_h_cs;
        logic             sound_found;
        logic             force_found;
    } result_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SND_GO,
        ST_SND_WAIT,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_FMUL_GO,
        ST_FMUL_WAIT,
        ST_LAST,
        ST_SMUL_GO,
        ST_SMUL_WAIT,
        ST_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

>>> hdl/cfl_ifs.sv
// Valid/ready channel interfaces for particle requests and result requests.
// Depends on cfl_pkg for field widths.
`default_nettype none

interface cfl_in_if;
    logic                           valid;
    logic                           ready;
    logic [cfl_pkg::VAL_W-1:0]      smoothing_length;
    logic [cfl_pkg::VAL_W-1:0]      sound_speed;
    logic signed [cfl_pkg::VAL_W-1:0] acceleration;
    logic                           ghost_flag;
    logic                           last_particle;

    modport source (
        output valid, smoothing_length, sound_speed, acceleration, ghost_flag, last_particle,
        input  ready
    );
    modport sink (
        input  valid, smoothing_length, sound_speed, acceleration, ghost_flag, last_particle,
        output ready
    );
endinterface

interface cfl_out_if;
    logic                      valid;
    logic                      ready;
    logic [cfl_pkg::VAL_W-1:0] time_step;
    logic [cfl_pkg::VAL_W-1:0] min_h_cs;
    logic                      sound_found;
    logic                      force_found;

    modport source (
        output valid, time_step, min_h_cs, sound_found, force_found,
        input  ready
    );
    modport sink (
        input  valid, time_step, min_h_cs, sound_found, force_found,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/cfl_timestep_min_reduction_top.sv
// Top level of the CFL timestep reduction: configuration registers, result
// output register and the particle sequencer. Depends on cfl_pkg, cfl_ifs, cfl_seq.
//
//   Channel    Direction  Handshake              Payload
//   particle   in         valid/ready            smoothing_length, sound_speed,
//                                                acceleration, ghost_flag, last_particle
//   result     out        valid/ready            time_step, min_h_cs, sound_found,
//                                                force_found
//   cfg        in         cfg_write_en           cfg_index, cfg_data
//
// A particle's sound and force terms run in turn through the single bit-serial
// unit; a ghost or a particle with no terms skips them. A last particle adds the
// sound multiply and waits for a free output register. Unit steps: 32 per divide
// (none if it saturates), 24 per square root, 16 per multiply. One particle is in
// work at a time; a finished result waits in the output register while further
// particles are taken. Reset restores register defaults and empty minima at once.
`default_nettype none

module cfl_timestep_min_reduction_top (
    input  logic                          clk,
    input  logic                          rst_n,
    cfl_in_if.sink                        particle,
    cfl_out_if.source                     result,
    input  logic                          cfg_write_en,
    input  logic [cfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfl_pkg::VAL_W-1:0]     cfg_data
);

    cfl_pkg::cfg_t    cfg_reg;
    cfl_pkg::result_t res;
    cfl_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             res_valid;
    logic             res_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sound_coeff <= cfl_pkg::COEF_W'(19661);
            cfg_reg.force_coeff <= cfl_pkg::COEF_W'(32768);
            cfg_reg.fixed_step  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                cfl_pkg::CFG_SOUND_COEFF: cfg_reg.sound_coeff <= cfg_data[cfl_pkg::COEF_W-1:0];
                cfl_pkg::CFG_FORCE_COEFF: cfg_reg.force_coeff <= cfg_data[cfl_pkg::COEF_W-1:0];
                cfl_pkg::CFG_FIXED_STEP:  cfg_reg.fixed_step  <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    cfl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .particle  (particle),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.time_step   = out_reg.time_step;
    assign result.min_h_cs    = out_reg.min_h_cs;
    assign result.sound_found = out_reg.sound_found;
    assign result.force_found = out_reg.force_found;

endmodule

`default_nettype wire

>>> hdl/cfl_arith.sv
// Shared bit-serial arithmetic unit: saturating Q16.16 divide, square root
// and coefficient multiply, one bit per cycle. Depends on cfl_pkg.
`default_nettype none

module cfl_arith (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfl_pkg::arith_cmd_t         cmd,
    input  logic [cfl_pkg::VAL_W-1:0]   opa,
    input  logic [cfl_pkg::VAL_W-1:0]   opb,
    input  logic [cfl_pkg::COEF_W-1:0]  coef,
    output logic [cfl_pkg::VAL_W-1:0]   result,
    output logic                        done
);

    localparam int unsigned VW = cfl_pkg::VAL_W;
    localparam int unsigned FW = cfl_pkg::FRAC_W;
    localparam int unsigned SW = cfl_pkg::SHF_W;
    localparam int unsigned RW = cfl_pkg::SQRT_STEPS;

    // Control registers.
    cfl_pkg::arith_op_t        op_reg, op_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [cfl_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Datapath registers: partial remainder or product, operand shift line,
    // quotient or root, divisor or multiplicand.
    logic [VW:0]   rem_reg, rem_next;
    logic [SW-1:0] shf_reg, shf_next;
    logic [VW-1:0] res_reg, res_next;
    logic [VW-1:0] den_reg, den_next;

    logic [VW:0]   div_rem2;
    logic [VW+1:0] div_diff;
    logic [RW+2:0] sq_rem2;
    logic [RW+2:0] sq_trial;
    logic [RW+3:0] sq_diff;
    logic [VW:0]   mul_sum;
    logic          div_sat;

    // One step of each operation.
    always_comb
    begin
        div_rem2 = {rem_reg[VW-1:0], shf_reg[SW-1]};
        div_diff = {1'b0, div_rem2} - {2'b00, den_reg};
        sq_rem2  = {rem_reg[RW:0], shf_reg[SW-1:SW-2]};
        sq_trial = {1'b0, res_reg[RW-1:0], 2'b01};
        sq_diff  = {1'b0, sq_rem2} - {1'b0, sq_trial};
        mul_sum  = {1'b0, rem_reg[VW-1:0]} + (shf_reg[0] ? {1'b0, den_reg} : '0);
        div_sat  = {{(VW-FW){1'b0}}, opa[VW-1:FW]} >= opb;
    end

    // Load on start, otherwise advance one step while busy.
    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        if (cmd.start)
        begin
            op_next   = cmd.op;
            busy_next = 1'b1;
            res_next  = '0;
            den_next  = opb;
            case (cmd.op)
                cfl_pkg::OP_DIV:
                begin
                    // The quotient fits only when h/2^16 is below the divisor.
                    rem_next = {{(VW-FW+1){1'b0}}, opa[VW-1:FW]};
                    shf_next = {opa[FW-1:0], {VW{1'b0}}};
                    cnt_next = cfl_pkg::CNT_W'(cfl_pkg::DIV_STEPS);
                    if (div_sat)
                    begin
                        res_next  = cfl_pkg::QMAX;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                cfl_pkg::OP_SQRT:
                begin
                    rem_next = '0;
                    shf_next = {opa, {FW{1'b0}}};
                    cnt_next = cfl_pkg::CNT_W'(cfl_pkg::SQRT_STEPS);
                end
                cfl_pkg::OP_MUL:
                begin
                    rem_next = '0;
                    shf_next = {{(SW-cfl_pkg::COEF_W){1'b0}}, coef};
                    cnt_next = cfl_pkg::CNT_W'(cfl_pkg::MUL_STEPS);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cfl_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            case (op_reg)
                cfl_pkg::OP_DIV:
                begin
                    shf_next = {shf_reg[SW-2:0], 1'b0};
                    if (!div_diff[VW+1])
                    begin
                        rem_next = div_diff[VW:0];
                        res_next = {res_reg[VW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = div_rem2;
                        res_next = {res_reg[VW-2:0], 1'b0};
                    end
                end
                cfl_pkg::OP_SQRT:
                begin
                    shf_next = {shf_reg[SW-3:0], 2'b00};
                    if (!sq_diff[RW+3])
                    begin
                        rem_next = {{(VW-RW-2){1'b0}}, sq_diff[RW+2:0]};
                        res_next = {res_reg[VW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {{(VW-RW-2){1'b0}}, sq_rem2};
                        res_next = {res_reg[VW-2:0], 1'b0};
                    end
                end
                cfl_pkg::OP_MUL:
                begin
                    // Right-shifting shift-add keeps only the high product bits.
                    shf_next = {1'b0, shf_reg[SW-1:1]};
                    rem_next = {1'b0, mul_sum[VW:1]};
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= cfl_pkg::OP_DIV;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        res_reg <= res_next;
        den_reg <= den_next;
    end

    assign result = (op_reg == cfl_pkg::OP_MUL) ? rem_reg[VW-1:0] : res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> hdl/cfl_seq.sv
// Particle sequencer: takes one particle, runs its terms through the serial
// unit, keeps the running minima and builds the result. Depends on cfl_pkg,
// cfl_ifs and cfl_arith.
`default_nettype none

module cfl_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    cfl_in_if.sink               particle,
    input  cfl_pkg::cfg_t        cfg,
    output logic                 res_valid,
    input  logic                 res_ready,
    output cfl_pkg::result_t     res
);

    localparam int unsigned VW = cfl_pkg::VAL_W;

    cfl_pkg::seq_state_t state_reg, state_next;

    // Captured particle.
    logic [VW-1:0] h_reg;
    logic [VW-1:0] cs_reg;
    logic [VW-1:0] amag_reg;
    logic          ghost_reg;
    logic          last_reg;

    // Running reduction state.
    logic [VW-1:0] min_hcs_reg;
    logic [VW-1:0] min_force_reg;
    logic          seen_sound_reg;
    logic          seen_force_reg;

    cfl_pkg::arith_cmd_t         cmd;
    logic [VW-1:0]               opa;
    logic [VW-1:0]               opb;
    logic [cfl_pkg::COEF_W-1:0]  coef;
    logic [VW-1:0]               unit_res;
    logic                        unit_done;

    logic          do_snd;
    logic          do_acc;
    logic          accept;
    logic [VW-1:0] amag_in;
    logic [VW-1:0] dt_min;

    cfl_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .coef   (coef),
        .result (unit_res),
        .done   (unit_done)
    );

    assign do_snd  = !ghost_reg && (cs_reg != '0);
    assign do_acc  = !ghost_reg && (amag_reg != '0);
    assign accept  = particle.valid && particle.ready;
    // Magnitude of the acceleration; the most negative value maps to 2^31.
    assign amag_in = particle.acceleration[VW-1] ? (~particle.acceleration + 1'b1)
                                                 : particle.acceleration;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfl_pkg::ST_IDLE:      if (particle.valid) state_next = cfl_pkg::ST_SND_GO;
            cfl_pkg::ST_SND_GO:    state_next = do_snd ? cfl_pkg::ST_SND_WAIT
                                                       : cfl_pkg::ST_ACC_GO;
            cfl_pkg::ST_SND_WAIT:  if (unit_done) state_next = cfl_pkg::ST_ACC_GO;
            cfl_pkg::ST_ACC_GO:    state_next = do_acc ? cfl_pkg::ST_ACC_WAIT
                                                       : cfl_pkg::ST_LAST;
            cfl_pkg::ST_ACC_WAIT:  if (unit_done) state_next = cfl_pkg::ST_SQRT_GO;
            cfl_pkg::ST_SQRT_GO:   state_next = cfl_pkg::ST_SQRT_WAIT;
            cfl_pkg::ST_SQRT_WAIT: if (unit_done) state_next = cfl_pkg::ST_FMUL_GO;
            cfl_pkg::ST_FMUL_GO:   state_next = cfl_pkg::ST_FMUL_WAIT;
            cfl_pkg::ST_FMUL_WAIT: if (unit_done) state_next = cfl_pkg::ST_LAST;
            cfl_pkg::ST_LAST:      state_next = last_reg ? cfl_pkg::ST_SMUL_GO
                                                         : cfl_pkg::ST_IDLE;
            cfl_pkg::ST_SMUL_GO:   state_next = cfl_pkg::ST_SMUL_WAIT;
            cfl_pkg::ST_SMUL_WAIT: if (unit_done) state_next = cfl_pkg::ST_EMIT;
            cfl_pkg::ST_EMIT:      if (res_ready) state_next = cfl_pkg::ST_IDLE;
            default:               state_next = cfl_pkg::ST_IDLE;
        endcase
    end

    // Outputs per state: unit commands, handshakes.
    always_comb
    begin
        cmd.start      = 1'b0;
        cmd.op         = cfl_pkg::OP_DIV;
        opa            = h_reg;
        opb            = cs_reg;
        coef           = cfg.force_coeff;
        particle.ready = 1'b0;
        res_valid      = 1'b0;
        case (state_reg)
            cfl_pkg::ST_IDLE:
            begin
                particle.ready = 1'b1;
            end
            cfl_pkg::ST_SND_GO:
            begin
                cmd.start = do_snd;
            end
            cfl_pkg::ST_ACC_GO:
            begin
                cmd.start = do_acc;
                opb       = amag_reg;
            end
            cfl_pkg::ST_SQRT_GO:
            begin
                // Root of the saturated quotient just produced.
                cmd.start = 1'b1;
                cmd.op    = cfl_pkg::OP_SQRT;
                opa       = unit_res;
            end
            cfl_pkg::ST_FMUL_GO:
            begin
                cmd.start = 1'b1;
                cmd.op    = cfl_pkg::OP_MUL;
                opb       = unit_res;
            end
            cfl_pkg::ST_SMUL_GO:
            begin
                cmd.start = 1'b1;
                cmd.op    = cfl_pkg::OP_MUL;
                opb       = min_hcs_reg;
                coef      = cfg.sound_coeff;
            end
            cfl_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // Result: a nonzero fixed step overrides the smaller of the sound and force terms.
    always_comb
    begin
        dt_min = (unit_res < min_force_reg) ? unit_res : min_force_reg;
        res.time_step   = (cfg.fixed_step != '0) ? cfg.fixed_step : dt_min;
        res.min_h_cs    = min_hcs_reg;
        res.sound_found = seen_sound_reg;
        res.force_found = seen_force_reg;
    end

    // State register and running reduction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfl_pkg::ST_IDLE;
            min_hcs_reg    <= cfl_pkg::QMAX;
            min_force_reg  <= cfl_pkg::QMAX;
            seen_sound_reg <= 1'b0;
            seen_force_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cfl_pkg::ST_SND_WAIT && unit_done)
            begin
                seen_sound_reg <= 1'b1;
                if (unit_res < min_hcs_reg)
                begin
                    min_hcs_reg <= unit_res;
                end
            end
            if (state_reg == cfl_pkg::ST_FMUL_WAIT && unit_done)
            begin
                seen_force_reg <= 1'b1;
                if (unit_res < min_force_reg)
                begin
                    min_force_reg <= unit_res;
                end
            end
            if (state_reg == cfl_pkg::ST_EMIT && res_ready)
            begin
                min_hcs_reg    <= cfl_pkg::QMAX;
                min_force_reg  <= cfl_pkg::QMAX;
                seen_sound_reg <= 1'b0;
                seen_force_reg <= 1'b0;
            end
        end
    end

    // Particle capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg     <= particle.smoothing_length;
            cs_reg    <= particle.sound_speed;
            amag_reg  <= amag_in;
            ghost_reg <= particle.ghost_flag;
            last_reg  <= particle.last_particle;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cfl_checker.sv
// Port-level checks for the CFL timestep reduction top level, and the bind
// that attaches them. Depends on cfl_timestep_min_reduction_top.
`default_nettype none

module cfl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] time_step,
    input  logic [31:0] min_h_cs,
    input  logic        sound_found
);

    // A result request that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its time_step and min_h_cs values.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(time_step) && $stable(min_h_cs))
        else $error("result payload changed while stalled");

    // Only one particle is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("particle taken while another is in work");

    // Without any sound particle the minimum stays at its empty value.
    a_empty_sound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sound_found |-> min_h_cs == 32'hFFFF_FFFF)
        else $error("min_h_cs reported without a sound particle");

endmodule

bind cfl_timestep_min_reduction_top cfl_checker u_cfl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (particle.valid),
    .in_ready    (particle.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .time_step   (result.time_step),
    .min_h_cs    (result.min_h_cs),
    .sound_found (result.sound_found)
);

`default_nettype wire
